// File: rtl/ccaa_pkg.sv
// ----------------------------------------------------------------------------
// ccaa_pkg: shared types and constants for the column consensus block
// class codes, class lookup, count storage types and the result bundle
// ----------------------------------------------------------------------------
package ccaa_pkg;

   localparam int CLASS_NUM   = 6;
   localparam int CLASS_IDX_W = 3;
   localparam int CODE_W      = 8;
   localparam int COUNT_W     = 11;
   localparam int COUNT_MAX   = 2047;

   typedef logic [CLASS_IDX_W-1:0] class_idx_type;
   typedef logic [CODE_W-1:0]      code_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef count_type [CLASS_NUM-1:0] count_array_type;

   // class order: first entry is also the class for unknown codes
   localparam code_type CLASS_CODE [CLASS_NUM] = '{
      8'd72, 8'd40, 8'd136, 8'd24, 8'd4, 8'd240
   };

   typedef struct packed {
      logic          update;
      logic          clear;
      class_idx_type cls;
   } count_ctrl_type;

   typedef struct packed {
      code_type consensus_code;
      code_type alternate_code;
      logic     has_alternate;
   } result_type;

   function automatic class_idx_type class_of(input code_type code);
      class_idx_type idx;
      idx = '0;
      for (int k = CLASS_NUM - 1; k >= 0; k--) begin
         if (CLASS_CODE[k] == code) begin
            idx = class_idx_type'(k);
         end
      end
      return idx;
   endfunction

endpackage

// File: rtl/ccaa_count_bank.sv
// ----------------------------------------------------------------------------
// ccaa_count_bank: per-class saturating counters
// increments one class per transaction, clears after the column end
// ----------------------------------------------------------------------------
module ccaa_count_bank #(
   parameter int unsigned MAX_SEQUENCES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ccaa_pkg::count_ctrl_type  ctrl,
   output ccaa_pkg::count_array_type counts_upd
);
   import ccaa_pkg::*;

   localparam int unsigned LimitInt =
      (MAX_SEQUENCES > COUNT_MAX) ? COUNT_MAX : MAX_SEQUENCES;
   localparam count_type CountLimit = count_type'(LimitInt);

   count_array_type counts_ff;
   count_array_type counts_in;

   always_comb begin
      for (int k = 0; k < CLASS_NUM; k++) begin
         counts_upd[k] = counts_ff[k];
         if (ctrl.update && ctrl.cls == class_idx_type'(k) && counts_ff[k] < CountLimit) begin
            counts_upd[k] = counts_ff[k] + count_type'(1);
         end
      end
      if (ctrl.clear) begin
         counts_in = '0;
      end else begin
         counts_in = counts_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '0;
      end else begin
         counts_ff <= counts_in;
      end
   end

   a_clear_zeroes : assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> counts_ff == '0)
      else $error("counts not cleared after column end");

   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      counts_ff[0] <= CountLimit && counts_ff[1] <= CountLimit &&
      counts_ff[2] <= CountLimit && counts_ff[3] <= CountLimit &&
      counts_ff[4] <= CountLimit && counts_ff[5] <= CountLimit)
      else $error("class count above saturation limit");

   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      !ctrl.update && !ctrl.clear |=> $stable(counts_ff))
      else $error("counts changed without a transaction");

endmodule

// File: rtl/ccaa_select.sv
// ----------------------------------------------------------------------------
// ccaa_select: column result selection
// strict-maximum consensus class and first non-reference nonzero class
// ----------------------------------------------------------------------------
module ccaa_select (
   input  ccaa_pkg::count_array_type counts,
   input  ccaa_pkg::code_type        reference_code,
   output ccaa_pkg::result_type      result
);
   import ccaa_pkg::*;

   class_idx_type best;
   class_idx_type alt;
   class_idx_type ref_cls;
   logic          alt_found;

   always_comb begin
      best = '0;
      for (int k = 1; k < CLASS_NUM; k++) begin
         if (counts[k] > counts[best]) begin
            best = class_idx_type'(k);
         end
      end

      ref_cls   = class_of(reference_code);
      alt       = '0;
      alt_found = 1'b0;
      // scan from the back so the earliest qualifying class wins
      for (int k = CLASS_NUM - 1; k >= 0; k--) begin
         if (class_idx_type'(k) != ref_cls && counts[k] != '0) begin
            alt       = class_idx_type'(k);
            alt_found = 1'b1;
         end
      end

      result.consensus_code = CLASS_CODE[best];
      result.has_alternate  = alt_found;
      result.alternate_code = alt_found ? CLASS_CODE[alt] : reference_code;
   end

endmodule

// File: rtl/column_consensus_and_alt_allele.sv
// ----------------------------------------------------------------------------
// column_consensus_and_alt_allele: alignment column consensus and alternate
// counts symbol classes per column and reports consensus and alternate codes
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one sequence's symbol per transaction; req_column_end marks
//   the last symbol of a column, and req_reference_code is taken with it.
//   rsp_ carries one result per column: consensus, alternate and flag.
// result path: a column's last symbol enters the input register when it is
//   accepted; the counter update and selection then write its result into
//   the result register.
// throughput: one symbol per cycle while req_stall is low; the single counter
//   bank is updated once per cycle and the six-way compare sits in the same cycle.
// reset: clears all class counts and the valid flags of the input register
//   and the result register.
// stall: a waiting result is held while rsp_stall is high; symbols keep being
//   counted, and req_stall rises only when a column end reaches the counters
//   while the result register is still occupied and rsp_stall is high.
// ----------------------------------------------------------------------------
module column_consensus_and_alt_allele #(
   parameter int unsigned MAX_SEQUENCES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ccaa_pkg::code_type  req_symbol_code,
   input  ccaa_pkg::code_type  req_reference_code,
   input  logic                req_column_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ccaa_pkg::code_type  rsp_consensus_code,
   output ccaa_pkg::code_type  rsp_alternate_code,
   output logic                rsp_has_alternate
);
   import ccaa_pkg::*;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   class_idx_type   s1_cls_ff;
   code_type        s1_ref_ff;
   logic            s1_end_ff;
   logic            s1_adv;
   logic            req_take;

   logic            out_valid_ff;
   logic            out_valid_in;
   result_type      out_ff;
   logic            out_load;

   count_ctrl_type  ctrl;
   count_array_type counts_upd;
   result_type      result;

   // a column end may only move on once the result register can take it
   assign s1_adv    = s1_valid_ff && !(s1_end_ff && out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign out_load  = s1_adv && s1_end_ff;

   assign ctrl.update = s1_adv;
   assign ctrl.clear  = out_load;
   assign ctrl.cls    = s1_cls_ff;

   ccaa_count_bank #(
      .MAX_SEQUENCES(MAX_SEQUENCES)
   ) u_count_bank (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .counts_upd (counts_upd)
   );

   ccaa_select u_select (
      .counts         (counts_upd),
      .reference_code (s1_ref_ff),
      .result         (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cls_ff <= class_of(req_symbol_code);
         s1_ref_ff <= req_reference_code;
         s1_end_ff <= req_column_end;
      end
      if (out_load) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_consensus_code = out_ff.consensus_code;
   assign rsp_alternate_code = out_ff.alternate_code;
   assign rsp_has_alternate  = out_ff.has_alternate;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(out_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_rsp_from_end : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff && s1_end_ff))
      else $error("result without a column end");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_end_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked column end");

   a_taken_leaves : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !out_load |=> !rsp_valid)
      else $error("taken result still valid");

endmodule

// File: tb/tb_column_consensus_and_alt_allele.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_consensus_and_alt_allele: column consensus block testbench
// streams alignment columns into the block, keeps its own class tally per
// column and checks every consensus/alternate result against it, with the
// request and result sides idling and stalling at random
// ----------------------------------------------------------------------------
module tb_column_consensus_and_alt_allele;
   import ccaa_pkg::*;

   localparam int unsigned MAX_SEQ     = 1024;
   localparam int unsigned COUNT_CAP   = (MAX_SEQ > COUNT_MAX) ? COUNT_MAX : MAX_SEQ;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          DRAIN_WAIT  = 10;
   localparam int          REPORT_MAX  = 10;

   typedef struct packed {
      code_type symbol;
      code_type refcode;
      logic     last;
   } column_item_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   code_type req_symbol_code = '0;
   code_type req_reference_code = '0;
   logic     req_column_end = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   code_type rsp_consensus_code;
   code_type rsp_alternate_code;
   logic     rsp_has_alternate;

   column_item_type pending_items [$];
   result_type      expected_results [$];
   count_type       column_counts [CLASS_NUM];
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   column_consensus_and_alt_allele #(
      .MAX_SEQUENCES (MAX_SEQ)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_symbol_code    (req_symbol_code),
      .req_reference_code (req_reference_code),
      .req_column_end     (req_column_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_consensus_code (rsp_consensus_code),
      .rsp_alternate_code (rsp_alternate_code),
      .rsp_has_alternate  (rsp_has_alternate)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // unknown codes fall into the first class
   function automatic int class_index(code_type code);
      int idx;
      idx = 0;
      for (int k = 1; k < CLASS_NUM; k++) begin
         if (CLASS_CODE[k] == code) begin
            idx = k;
         end
      end
      return idx;
   endfunction

   function automatic code_type random_symbol(int favourite);
      int r;
      r = $urandom_range(0, 99);
      if (favourite >= 0 && r < 50) begin
         return CLASS_CODE[favourite];
      end else if (r < 80) begin
         return CLASS_CODE[$urandom_range(0, CLASS_NUM - 1)];
      end
      return code_type'($urandom_range(0, 255));
   endfunction

   task automatic push_item(input code_type symbol, input code_type refcode,
                            input logic last);
      column_item_type item;
      item.symbol  = symbol;
      item.refcode = refcode;
      item.last    = last;
      pending_items.push_back(item);
   endtask

   task automatic push_random_columns(input int n_items);
      int       queued;
      int       len;
      int       favourite;
      code_type refcode;
      queued = 0;
      while (queued < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
         favourite = $urandom_range(0, 1) ? $urandom_range(0, CLASS_NUM - 1) : -1;
         for (int i = 0; i < len; i++) begin
            // reference only matters on the column end, so it is noise elsewhere
            if (i == len - 1 && $urandom_range(0, 99) < 70) begin
               refcode = CLASS_CODE[$urandom_range(0, CLASS_NUM - 1)];
            end else begin
               refcode = code_type'($urandom_range(0, 255));
            end
            push_item(random_symbol(favourite), refcode, i == len - 1);
         end
         queued += len;
      end
   endtask

   // holds off new stimulus until the block has returned every result
   task automatic wait_until_idle();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input result_type exp_res,
                                  input result_type act_res);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("[%0t] %s: expected cons=%0d alt=%0d has=%0b, got cons=%0d alt=%0d has=%0b",
                  $time, what, exp_res.consensus_code, exp_res.alternate_code,
                  exp_res.has_alternate, act_res.consensus_code,
                  act_res.alternate_code, act_res.has_alternate);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      column_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            item = pending_items.pop_front();
            req_valid          <= 1'b1;
            req_symbol_code    <= item.symbol;
            req_reference_code <= item.refcode;
            req_column_end     <= item.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // column tally: mirrors the block's counters on every accepted transaction
   always @(posedge clock) begin
      int         sym_cls;
      int         ref_cls;
      int         best;
      int         alt;
      result_type res;
      if (reset) begin
         for (int k = 0; k < CLASS_NUM; k++) begin
            column_counts[k] = '0;
         end
      end else if (req_valid && !req_stall) begin
         sym_cls = class_index(req_symbol_code);
         if (column_counts[sym_cls] < COUNT_CAP) begin
            column_counts[sym_cls] = column_counts[sym_cls] + 1'b1;
         end
         if (req_column_end) begin
            best = 0;
            for (int k = 1; k < CLASS_NUM; k++) begin
               if (column_counts[k] > column_counts[best]) begin
                  best = k;
               end
            end
            ref_cls = class_index(req_reference_code);
            alt = -1;
            for (int k = CLASS_NUM - 1; k >= 0; k--) begin
               if (k != ref_cls && column_counts[k] != 0) begin
                  alt = k;
               end
            end
            res.consensus_code = CLASS_CODE[best];
            res.has_alternate  = (alt >= 0);
            res.alternate_code = (alt >= 0) ? CLASS_CODE[alt] : req_reference_code;
            expected_results.push_back(res);
            for (int k = 0; k < CLASS_NUM; k++) begin
               column_counts[k] = '0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type act_res;
      result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         act_res.consensus_code = rsp_consensus_code;
         act_res.alternate_code = rsp_alternate_code;
         act_res.has_alternate  = rsp_has_alternate;
         if (expected_results.size() == 0) begin
            exp_res = '0;
            report_mismatch("unexpected result", exp_res, act_res);
         end else begin
            exp_res = expected_results.pop_front();
            if (act_res.consensus_code != exp_res.consensus_code ||
                act_res.alternate_code != exp_res.alternate_code ||
                act_res.has_alternate != exp_res.has_alternate) begin
               report_mismatch("result mismatch", exp_res, act_res);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      sender_idle_pct    = 22;
      receiver_stall_pct = 68;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single-symbol columns, unknown symbol and unknown reference
      push_item(8'd72, 8'd72, 1'b1);
      push_item(8'd0, 8'd255, 1'b1);
      // every class but 72 present, reference excludes class 40
      push_item(8'd40, 8'd0, 1'b0);
      push_item(8'd136, 8'd17, 1'b0);
      push_item(8'd136, 8'd255, 1'b0);
      push_item(8'd24, 8'd128, 1'b0);
      push_item(8'd4, 8'd1, 1'b0);
      push_item(8'd240, 8'd254, 1'b0);
      push_item(8'd240, 8'd72, 1'b0);
      push_item(8'd240, 8'd40, 1'b1);
      // tie between two classes goes to the earlier one
      push_item(8'd24, 8'd0, 1'b0);
      push_item(8'd4, 8'd0, 1'b0);
      push_item(8'd4, 8'd0, 1'b0);
      push_item(8'd24, 8'd4, 1'b1);
      // unknown symbols pile onto class 72
      push_item(8'd255, 8'd0, 1'b0);
      push_item(8'd1, 8'd0, 1'b0);
      push_item(8'd72, 8'd136, 1'b1);
      // only the reference class seen: raw reference comes back
      push_item(8'd240, 8'd0, 1'b0);
      push_item(8'd240, 8'd240, 1'b1);
      wait_until_idle();

      // long column: 136 runs into the count limit and still leads
      for (int i = 0; i < 1030; i++) begin
         push_item(8'd136, code_type'($urandom_range(0, 255)), 1'b0);
      end
      for (int i = 0; i < 6; i++) begin
         push_item(8'd40, code_type'($urandom_range(0, 255)), i == 5);
      end
      wait_until_idle();

      push_random_columns(270);
      wait_until_idle();

      sender_idle_pct    = 68;
      receiver_stall_pct = 22;
      push_random_columns(270);
      wait_until_idle();

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      push_random_columns(255);
      wait_until_idle();

      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: column_consensus_and_alt_allele.f
rtl/ccaa_pkg.sv
rtl/ccaa_count_bank.sv
rtl/ccaa_select.sv
rtl/column_consensus_and_alt_allele.sv
tb/tb_column_consensus_and_alt_allele.sv
